FILE: rtl/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants for the signed fixed-point ALU: action codes,
// status codes and default word and fraction widths.
// ----------------------------------------------------------------------------
package fpq_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_MUL   = 4'd2,
    ACT_DIV   = 4'd3,
    ACT_GT    = 4'd4,
    ACT_LT    = 4'd5,
    ACT_GE    = 4'd6,
    ACT_LE    = 4'd7,
    ACT_EQ    = 4'd8,
    ACT_NE    = 4'd9,
    ACT_MIN   = 4'd10,
    ACT_MAX   = 4'd11,
    ACT_INC   = 4'd12,
    ACT_DEC   = 4'd13,
    ACT_TOINT = 4'd14
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

endpackage

FILE: rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed fixed-point ALU with exact saturating arithmetic, rounded multiply
// and divide, comparisons, min/max, step and integer conversion.
// ----------------------------------------------------------------------------
// every action passes through every stage from start to out_strobe; the pipeline
// depth is set by the divider, one quotient bit a stage
// throughput: one beat per cycle, busy stays low
// results appear for one cycle on out_strobe; the receiver cannot stall
// reset clears the stage valid bits only; no item is in flight afterwards
module fixed_point_q24_8_alu
  import fpq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_action,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_strobe,
  output logic signed [WORD_BITS-1:0] out_result_raw,
  output logic                        out_compare_true,
  output logic [1:0]                  out_status
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NB  = W + F;
  localparam int D   = NB;
  localparam int LAT = D + 3;
  localparam int H   = (W + 1) / 2;
  localparam int PW  = 2 * W;
  localparam int PLL = 2 * H;
  localparam int PHH = 2 * (W - H);

  localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};
  localparam logic [PW-1:0] RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

  typedef struct packed {
    logic            vld;
    action_t         act;
    logic [W-1:0]    a;
    logic [W-1:0]    b;
    logic [W-1:0]    ma;
    logic [W-1:0]    mb;
    logic            na;
    logic            neg;
    logic            is_div;
    logic [NB-1:0]   num;
    logic [W-1:0]    rem;
    logic [NB-1:0]   q;
    logic [PLL-1:0]  pp_ll;
    logic [W-1:0]    pp_lh;
    logic [W-1:0]    pp_hl;
    logic [PHH-1:0]  pp_hh;
    logic [PW-1:0]   prod;
    logic [W-1:0]    res;
    logic            cmp;
    status_t         st;
  } stage_t;

  stage_t p_r   [1:LAT];
  stage_t p_nxt [1:LAT];

  assign busy = 1'b0;

  // decode operands into sign and magnitude
  always_comb begin
    p_nxt[1]     = '0;
    p_nxt[1].vld = start;
    p_nxt[1].act = action_t'(in_action);
    p_nxt[1].a   = in_operand_a;
    p_nxt[1].b   = in_operand_b;
    p_nxt[1].na  = in_operand_a[W-1];
    p_nxt[1].neg = in_operand_a[W-1] ^ in_operand_b[W-1];
    p_nxt[1].ma  = in_operand_a[W-1] ? (~in_operand_a + ONE_W) : in_operand_a;
    p_nxt[1].mb  = in_operand_b[W-1] ? (~in_operand_b + ONE_W) : in_operand_b;
    p_nxt[1].num = {p_nxt[1].ma, {F{1'b0}}};
    p_nxt[1].st  = ST_OK;
  end

  genvar k;
  generate
    for (k = 2; k <= LAT; k++) begin : g_stage
      always_comb begin
        logic [W:0]    rem_w;
        logic [W:0]    rem_s;
        logic [W-1:0]  y;
        logic          cin;
        logic [W:0]    sum;
        logic          lt;
        logic          eq;
        logic [W-1:0]  ti;
        logic [W-1:0]  lim;
        logic [PW-1:0] pr;
        logic [PW-1:0] pm;
        logic          rnd;
        logic [NB:0]   qr;
        stage_t        prv;

        prv      = p_r[k-1];
        p_nxt[k] = prv;
        lim      = prv.neg ? MINV : MAXV;
        rem_w    = {prv.rem, prv.num[NB-1]};
        rem_s    = rem_w - {1'b0, prv.mb};
        y        = '0;
        cin      = 1'b0;
        sum      = '0;
        lt       = $signed(prv.a) < $signed(prv.b);
        eq       = (prv.a == prv.b);
        ti       = prv.ma >> F;
        pr       = prv.prod + RND_HALF;
        pm       = pr >> F;
        rnd      = {prv.rem, 1'b0} >= {1'b0, prv.mb};
        qr       = {1'b0, prv.q} + {{NB{1'b0}}, rnd};

        // restoring divide, one quotient bit per stage
        if (k <= D + 1) begin
          p_nxt[k].num = {prv.num[NB-2:0], 1'b0};
          if (rem_w >= {1'b0, prv.mb}) begin
            p_nxt[k].rem = rem_s[W-1:0];
            p_nxt[k].q   = {prv.q[NB-2:0], 1'b1};
          end else begin
            p_nxt[k].rem = rem_w[W-1:0];
            p_nxt[k].q   = {prv.q[NB-2:0], 1'b0};
          end
        end

        if (k == 2) begin
          p_nxt[k].res    = '0;
          p_nxt[k].cmp    = 1'b0;
          p_nxt[k].st     = ST_OK;
          p_nxt[k].is_div = 1'b0;
          p_nxt[k].pp_ll  = prv.ma[H-1:0] * prv.mb[H-1:0];
          p_nxt[k].pp_lh  = prv.ma[H-1:0] * prv.mb[W-1:H];
          p_nxt[k].pp_hl  = prv.ma[W-1:H] * prv.mb[H-1:0];
          p_nxt[k].pp_hh  = prv.ma[W-1:H] * prv.mb[W-1:H];
          case (prv.act)
            ACT_ADD: y = prv.b;
            ACT_SUB: begin
              y   = ~prv.b;
              cin = 1'b1;
            end
            ACT_INC: y = ONE_W;
            ACT_DEC: y = '1;
            default: y = '0;
          endcase
          sum = {prv.a[W-1], prv.a} + {y[W-1], y} + {{W{1'b0}}, cin};
          case (prv.act) inside
            ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
              if (sum[W] != sum[W-1]) begin
                p_nxt[k].res = sum[W] ? MINV : MAXV;
                p_nxt[k].st  = ST_OVF;
              end else begin
                p_nxt[k].res = sum[W-1:0];
              end
            end
            ACT_DIV: begin
              if (prv.mb == '0) begin
                p_nxt[k].st = ST_DIVZ;
              end else begin
                p_nxt[k].is_div = 1'b1;
              end
            end
            ACT_GT:    p_nxt[k].cmp = !lt && !eq;
            ACT_LT:    p_nxt[k].cmp = lt;
            ACT_GE:    p_nxt[k].cmp = !lt;
            ACT_LE:    p_nxt[k].cmp = lt || eq;
            ACT_EQ:    p_nxt[k].cmp = eq;
            ACT_NE:    p_nxt[k].cmp = !eq;
            ACT_MIN:   p_nxt[k].res = lt ? prv.a : prv.b;
            ACT_MAX:   p_nxt[k].res = (!lt && !eq) ? prv.a : prv.b;
            ACT_TOINT: p_nxt[k].res = prv.na ? (~ti + ONE_W) : ti;
            default: ;
          endcase
        end

        // multiply: sum partials, round and clamp, apply sign
        if (k == 3) begin
          p_nxt[k].prod = PW'(prv.pp_ll) + (PW'(prv.pp_lh) << H)
                        + (PW'(prv.pp_hl) << H) + (PW'(prv.pp_hh) << (2 * H));
        end
        if (k == 4 && prv.act == ACT_MUL) begin
          if (pm > {{W{1'b0}}, lim}) begin
            p_nxt[k].res = lim;
            p_nxt[k].st  = ST_OVF;
          end else begin
            p_nxt[k].res = pm[W-1:0];
          end
        end
        if (k == 5 && prv.act == ACT_MUL && prv.neg) begin
          p_nxt[k].res = ~prv.res + ONE_W;
        end

        // divide: round half away from zero, clamp, apply sign
        if (k == D + 2 && prv.is_div) begin
          if (qr > {{(NB+1-W){1'b0}}, lim}) begin
            p_nxt[k].res = lim;
            p_nxt[k].st  = ST_OVF;
          end else begin
            p_nxt[k].res = qr[W-1:0];
          end
        end
        if (k == D + 3 && prv.is_div && prv.neg) begin
          p_nxt[k].res = ~prv.res + ONE_W;
        end
      end
    end
  endgenerate

  genvar j;
  generate
    for (j = 1; j <= LAT; j++) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          p_r[j].vld <= 1'b0;
        end else begin
          p_r[j] <= p_nxt[j];
        end
      end
    end
  endgenerate

  assign out_strobe       = p_r[LAT].vld;
  assign out_result_raw   = p_r[LAT].res;
  assign out_compare_true = p_r[LAT].cmp;
  assign out_status       = p_r[LAT].st;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted beat did not emerge after pipeline latency");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_DIVZ) |-> (out_result_raw == '0 && !out_compare_true))
    else $error("divide by zero result not cleared");

  a_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_compare_true) |->
      (p_r[LAT].act == ACT_GT || p_r[LAT].act == ACT_LT || p_r[LAT].act == ACT_GE ||
       p_r[LAT].act == ACT_LE || p_r[LAT].act == ACT_EQ || p_r[LAT].act == ACT_NE))
    else $error("compare flag set on non-compare action");

  a_ovf_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OVF) |->
      (p_r[LAT].act == ACT_ADD || p_r[LAT].act == ACT_SUB || p_r[LAT].act == ACT_MUL ||
       p_r[LAT].act == ACT_DIV || p_r[LAT].act == ACT_INC || p_r[LAT].act == ACT_DEC))
    else $error("overflow flagged on non-arithmetic action");

endmodule
